### hw/rtl/csl_pkg.sv
package csl_pkg;

  // List geometry
  localparam int NUM_SLOTS = 16;
  localparam int SLOT_W    = 4;   // bits of a slot index
  localparam int CNT_W     = 5;   // bits of the fill count (0 .. NUM_SLOTS)
  localparam int KEY_W     = 32;
  localparam int HANDLE_W  = 16;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_REJECT   = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_e;

  // Register indexes on the configuration port
  localparam logic REG_ENABLE   = 1'b0;
  localparam logic REG_CAPACITY = 1'b1;

  // Operation broadcast to every cell
  typedef struct packed {
    logic                put;       // successful put this cycle
    logic                withdraw;  // withdraw search this cycle
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    logic [CNT_W-1:0]    count;     // fill level before the operation
  } cell_ctrl_t;

endpackage

### hw/rtl/compacting_slot_list_unit.sv
// Channel | Handshake                   | Payload
// --------+-----------------------------+----------------------------------------------
// in      | start & !busy               | mode_i entry_key_i entry_handle_i
//         |                             | entry_present_i entry_blank_i
// out     | done_o (one-cycle strobe)   | status_o slot_index_o found_handle_o fill_level_o
// cfg     | psel & penable & pwrite     | paddr pwdata (prdata on reads), pready high
//
// One word per cycle: the result of an accepted word is registered and shows in the
// cycle after it, on done_o for one cycle. The search, first-hit pick and shift run
// combinationally through the row of slot cells, so busy stays low. Reset clears the
// fill level, the configuration registers and the result strobe; slot contents and
// result fields are not cleared. The receiver cannot stall the result.
module compacting_slot_list_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // operation
  input  logic                          start,
  output logic                          busy,
  input  logic                          mode_i,
  input  logic [csl_pkg::KEY_W-1:0]     entry_key_i,
  input  logic [csl_pkg::HANDLE_W-1:0]  entry_handle_i,
  input  logic                          entry_present_i,
  input  logic                          entry_blank_i,
  // result
  output logic                          done_o,
  output logic [1:0]                    status_o,
  output logic [csl_pkg::SLOT_W-1:0]    slot_index_o,
  output logic [csl_pkg::HANDLE_W-1:0]  found_handle_o,
  output logic [csl_pkg::CNT_W-1:0]     fill_level_o,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import csl_pkg::*;

  logic                enable_q;
  logic [CNT_W-1:0]    capacity_q;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    cap_sat;
  logic                accept;
  logic                usable;
  logic                put_ok;
  logic                wd_en;
  logic                found;
  cell_ctrl_t          ctrl;

  logic                done_q;
  status_e             status_q, status_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [HANDLE_W-1:0] handle_q, handle_d;

  logic [NUM_SLOTS:0]                 hit_chain;
  logic [NUM_SLOTS:0][HANDLE_W-1:0]   found_chain;
  logic [NUM_SLOTS-1:0][KEY_W-1:0]    cell_key;
  logic [NUM_SLOTS-1:0][HANDLE_W-1:0] cell_handle;

  assign busy   = 1'b0;
  assign pready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b0;
      capacity_q <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_ENABLE:   enable_q   <= pwdata[0];
        REG_CAPACITY: capacity_q <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_ENABLE:   prdata[0]         = enable_q;
      REG_CAPACITY: prdata[CNT_W-1:0] = capacity_q;
      default: ;
    endcase
  end

  // Operation decode
  assign cap_sat = (capacity_q > CNT_W'(NUM_SLOTS)) ? CNT_W'(NUM_SLOTS) : capacity_q;
  assign accept  = start && !busy;
  assign usable  = enable_q && (cap_sat != '0);
  assign put_ok  = accept && usable && !mode_i && (count_q < cap_sat)
                   && entry_present_i && !entry_blank_i;
  assign wd_en   = accept && usable && mode_i;

  assign ctrl.put      = put_ok;
  assign ctrl.withdraw = wd_en;
  assign ctrl.key      = entry_key_i;
  assign ctrl.handle   = entry_handle_i;
  assign ctrl.count    = count_q;

  // Row of slot cells; the top cell feeds itself as its upper neighbour
  assign hit_chain[0]   = 1'b0;
  assign found_chain[0] = '0;

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    logic [KEY_W-1:0]    nkey;
    logic [HANDLE_W-1:0] nhandle;
    if (i == NUM_SLOTS - 1) begin : g_top
      assign nkey    = cell_key[i];
      assign nhandle = cell_handle[i];
    end else begin : g_mid
      assign nkey    = cell_key[i+1];
      assign nhandle = cell_handle[i+1];
    end
    csl_cell u_cell (
      .clk_i        (clk_i),
      .cell_idx_i   (SLOT_W'(i)),
      .ctrl_i       (ctrl),
      .next_key_i   (nkey),
      .next_handle_i(nhandle),
      .hit_i        (hit_chain[i]),
      .found_i      (found_chain[i]),
      .hit_o        (hit_chain[i+1]),
      .found_o      (found_chain[i+1]),
      .key_o        (cell_key[i]),
      .handle_o     (cell_handle[i])
    );
  end

  assign found = hit_chain[NUM_SLOTS];

  // Fill level and result word
  always_comb begin
    count_d  = count_q;
    status_d = ST_REJECT;
    slot_d   = '0;
    handle_d = '0;
    if (put_ok) begin
      count_d  = count_q + CNT_W'(1);
      status_d = ST_OK;
      slot_d   = count_q[SLOT_W-1:0];
    end else if (wd_en && found) begin
      count_d  = count_q - CNT_W'(1);
      status_d = ST_OK;
      handle_d = found_chain[NUM_SLOTS];
    end else if (wd_en) begin
      status_d = ST_NOTFOUND;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      slot_q   <= slot_d;
      handle_q <= handle_d;
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign slot_index_o   = slot_q;
  assign found_handle_o = handle_q;
  assign fill_level_o   = count_q;

  // Checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(NUM_SLOTS))
    else $error("fill level above slot count");

  a_fill_only_on_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(count_q))
    else $error("fill level moved without an operation");

  a_put_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    put_ok |=> (done_o && status_o == ST_OK && slot_index_o == $past(count_q[SLOT_W-1:0])
                && fill_level_o == $past(count_q) + CNT_W'(1)))
    else $error("put result does not match fill level");

  a_reject_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !usable) |=> (status_o == ST_REJECT && $stable(count_q)))
    else $error("operation on unusable list was not rejected");

endmodule

### hw/rtl/csl_cell.sv
module csl_cell (
  input  logic                        clk_i,
  input  logic [csl_pkg::SLOT_W-1:0]  cell_idx_i,
  input  csl_pkg::cell_ctrl_t         ctrl_i,
  // data of the next cell up the chain
  input  logic [csl_pkg::KEY_W-1:0]    next_key_i,
  input  logic [csl_pkg::HANDLE_W-1:0] next_handle_i,
  // hit and found handle from the cells below
  input  logic                        hit_i,
  input  logic [csl_pkg::HANDLE_W-1:0] found_i,
  output logic                        hit_o,
  output logic [csl_pkg::HANDLE_W-1:0] found_o,
  output logic [csl_pkg::KEY_W-1:0]    key_o,
  output logic [csl_pkg::HANDLE_W-1:0] handle_o
);
  import csl_pkg::*;

  logic [KEY_W-1:0]    key_q, key_d;
  logic [HANDLE_W-1:0] handle_q, handle_d;
  logic                occupied;
  logic                match;
  logic                first;

  // Compare against the searched key; only occupied slots take part
  assign occupied = {1'b0, cell_idx_i} < ctrl_i.count;
  assign match    = ctrl_i.withdraw && occupied && (key_q == ctrl_i.key);
  assign first    = match && !hit_i;
  assign hit_o    = hit_i | match;
  assign found_o  = found_i | (first ? handle_q : '0);

  // Put writes the slot at the fill level; a withdraw shifts down from the hit
  always_comb begin
    key_d    = key_q;
    handle_d = handle_q;
    if (ctrl_i.put && ({1'b0, cell_idx_i} == ctrl_i.count)) begin
      key_d    = ctrl_i.key;
      handle_d = ctrl_i.handle;
    end else if (ctrl_i.withdraw && hit_o) begin
      key_d    = next_key_i;
      handle_d = next_handle_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    handle_q <= handle_d;
  end

  assign key_o    = key_q;
  assign handle_o = handle_q;

endmodule
